FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

FILE: hw/rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared constants, types and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rdc_pkg;

	localparam int VALUE_BITS = 31;
	localparam int MAX_DIGITS = 31;
	localparam int IN_BITS    = 32;
	localparam int RADIX_BITS = 5;
	localparam int DIGIT_BITS = 4;
	localparam int CHAR_BITS  = 7;
	localparam int ADDR_BITS  = $clog2(MAX_DIGITS);
	localparam int CNT_BITS   = $clog2(MAX_DIGITS + 1);
	localparam int STEP_BITS  = $clog2(VALUE_BITS);
	localparam int S_TDATA_BITS = 40;
	localparam int M_TDATA_BITS = 16;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN = RADIX_BITS'(2);
	localparam logic [RADIX_BITS-1:0] RADIX_MAX = RADIX_BITS'(16);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_POP  = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic pop;
	} cmd_t;

	typedef struct packed {
		logic in_ok;
		logic div_last;
		logic quot_zero;
		logic last_pop;
	} sts_t;

	function automatic logic [CHAR_BITS-1:0] char_of(input logic [DIGIT_BITS-1:0] d);
		logic [CHAR_BITS-1:0] dx;
		dx = CHAR_BITS'(d);
		return (d < DIGIT_BITS'(10)) ? (CHAR_BITS'(48) + dx) : (CHAR_BITS'(55) + dx);
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rdc_ctrl.sv
// ----------------------------------------------------------------------------
// rdc_ctrl
// Sequencer: accept, divide digit by digit, pop and present each digit.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_ctrl import rdc_pkg::*; (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  s_tvalid,
	output logic s_tready,
	output logic m_tvalid,
	input  wire  m_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				// drop items that give no digits
				if (s_tvalid && sts.in_ok) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last && sts.quot_zero) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					state_d = sts.last_pop ? ST_IDLE : ST_POP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/rdc_dp.sv
// ----------------------------------------------------------------------------
// rdc_dp
// Bit-serial restoring divider, digit stack and output digit register.
// ----------------------------------------------------------------------------
`default_nettype none

module rdc_dp import rdc_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire  [IN_BITS-1:0]     value,
	input  wire  [RADIX_BITS-1:0]  radix,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	output logic [DIGIT_BITS-1:0]  digit_value,
	output logic                   last_digit
);

	logic [VALUE_BITS-1:0] quot_q, quot_next;
	logic [RADIX_BITS-1:0] radix_q;
	logic [DIGIT_BITS-1:0] rem_q, rem_next;
	logic [STEP_BITS-1:0]  step_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [DIGIT_BITS-1:0] rd_q;
	logic                  last_q;
	logic [DIGIT_BITS-1:0] stack_mem [MAX_DIGITS];
	logic [RADIX_BITS-1:0] trial;
	logic                  ge;
	logic                  push;
	logic [ADDR_BITS-1:0]  wr_addr, rd_addr;

	// one quotient bit per cycle
	assign trial     = {rem_q, quot_q[VALUE_BITS-1]};
	assign ge        = (trial >= radix_q);
	assign rem_next  = ge ? DIGIT_BITS'(trial - radix_q) : trial[DIGIT_BITS-1:0];
	assign quot_next = {quot_q[VALUE_BITS-2:0], ge};

	assign sts.in_ok     = !value[IN_BITS-1] && (value != '0)
	                       && (radix >= RADIX_MIN) && (radix <= RADIX_MAX);
	assign sts.div_last  = (step_q == STEP_BITS'(VALUE_BITS - 1));
	assign sts.quot_zero = (quot_next == '0);
	assign sts.last_pop  = last_q;

	assign push    = cmd.div_step && sts.div_last && (cnt_q < CNT_BITS'(MAX_DIGITS));
	assign wr_addr = ADDR_BITS'(cnt_q);
	assign rd_addr = ADDR_BITS'(cnt_q - CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			step_q <= '0;
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				quot_q <= VALUE_BITS'(value);
				step_q <= '0;
				cnt_q  <= '0;
			end else if (cmd.div_step) begin
				quot_q <= quot_next;
				step_q <= sts.div_last ? '0 : step_q + STEP_BITS'(1);
				if (push) begin
					cnt_q <= cnt_q + CNT_BITS'(1);
				end
			end else if (cmd.pop) begin
				cnt_q  <= cnt_q - CNT_BITS'(1);
				last_q <= (cnt_q == CNT_BITS'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			radix_q <= radix;
			rem_q   <= '0;
		end else if (cmd.div_step) begin
			// clear the remainder once the digit is pushed
			rem_q <= sts.div_last ? '0 : rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[wr_addr] <= rem_next;
		end
		if (cmd.pop) begin
			rd_q <= stack_mem[rd_addr];
		end
	end

	assign digit_value = rd_q;
	assign last_digit  = last_q;

endmodule

`default_nettype wire

FILE: hw/rtl/radix_digit_converter_unit.sv
// Flow: the input beat is loaded, the divider runs one digit after another, then each digit
// is read from the stack and presented as an output beat, which waits until the sink is ready.
// Throughput: one item at a time; a new beat is taken only after the last digit has left.
// The bit-serial divider computes one quotient bit per cycle.
// Reset: arst_n asynchronous, active low; sequencer returns to idle, counters clear.
// ----------------------------------------------------------------------------
// radix_digit_converter_unit
// Converts a positive integer to its digits in radix 2..16, most significant
// digit first, each digit with its ASCII character and a last-digit flag.
// ----------------------------------------------------------------------------
`default_nettype none

module radix_digit_converter_unit import rdc_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	// slave side: value [31:0], radix [36:32], unused [39:37]
	input  wire                      s_tvalid,
	output logic                     s_tready,
	input  wire  [S_TDATA_BITS-1:0]  s_tdata,
	// master side: digit_value [3:0], digit_char [10:4], zero [15:11]
	output logic                     m_tvalid,
	input  wire                      m_tready,
	output logic [M_TDATA_BITS-1:0]  m_tdata,
	// last_digit: final, least significant digit of the run
	output logic                     m_tlast
);

	cmd_t                  cmd;
	sts_t                  sts;
	logic [DIGIT_BITS-1:0] digit_value;
	logic [CHAR_BITS-1:0]  digit_char;

	// Sequencer: takes a beat only when idle; beats that give no digits
	// (zero or negative value, radix outside 2..16) are taken and dropped.
	rdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Datapath: divide by the radix one bit a cycle, push each remainder,
	// then pop into the output register, most significant digit first.
	rdc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.value       (s_tdata[IN_BITS-1:0]),
		.radix       (s_tdata[IN_BITS+RADIX_BITS-1:IN_BITS]),
		.cmd         (cmd),
		.sts         (sts),
		.digit_value (digit_value),
		.last_digit  (m_tlast)
	);

	// ASCII: '0'..'9' then 'A'..'F'
	assign digit_char = char_of(digit_value);
	assign m_tdata    = M_TDATA_BITS'({digit_char, digit_value});

endmodule

`default_nettype wire

FILE: hw/rtl/rdc_checker.sv
// ----------------------------------------------------------------------------
// rdc_checker
// Port-level checks of the radix digit converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rdc_port_checker import rdc_pkg::*; (
	input wire                     clk,
	input wire                     arst_n,
	input wire                     s_tready,
	input wire                     m_tvalid,
	input wire                     m_tready,
	input wire [M_TDATA_BITS-1:0]  m_tdata,
	input wire                     m_tlast
);

	logic [CHAR_BITS-1:0] exp_char;

	assign exp_char = char_of(m_tdata[DIGIT_BITS-1:0]);

	`ASSERT_NEVER(a_no_overlap, clk, arst_n, m_tvalid && s_tready,
		"input taken while digit pending")
	`ASSERT_CLK(a_out_hold, clk, arst_n,
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast),
		"stalled digit beat changed")
	`ASSERT_CLK(a_char_ok, clk, arst_n,
		m_tvalid |-> m_tdata[DIGIT_BITS+CHAR_BITS-1:DIGIT_BITS] == exp_char,
		"digit character mismatch")
	`ASSERT_CLK(a_pad_zero, clk, arst_n,
		m_tvalid |-> m_tdata[M_TDATA_BITS-1:DIGIT_BITS+CHAR_BITS] == '0,
		"padding bits not zero")
	`ASSERT_CLK(a_idle_after_last, clk, arst_n,
		m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid,
		"not idle after final digit")

endmodule

bind radix_digit_converter_unit rdc_port_checker u_rdc_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

`default_nettype wire

FILE: dv/rdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_checker
// Watches both stream channels of the radix digit converter, predicts the
// digit string of each accepted value and compares every digit beat with it.
// ----------------------------------------------------------------------------
module rdc_checker import rdc_pkg::*; (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      s_tvalid,
	input  wire                      s_tready,
	input  wire  [S_TDATA_BITS-1:0]  s_tdata,
	input  wire                      m_tvalid,
	input  wire                      m_tready,
	input  wire  [M_TDATA_BITS-1:0]  m_tdata,
	input  wire                      m_tlast,
	output int                       fail_count,
	output int                       pending
);

	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic [DIGIT_BITS-1:0] dval;
		logic [CHAR_BITS-1:0]  dchar;
		logic                  dlast;
	} digit_beat_t;

	digit_beat_t           digit_fifo[$];
	logic [DIGIT_BITS-1:0] shadow_stack [MAX_DIGITS];
	int unsigned           shadow_depth;
	logic [VALUE_BITS-1:0] shadow_quot;
	int                    mismatch_total;

	initial begin
		fail_count     = 0;
		pending        = 0;
		mismatch_total = 0;
		shadow_depth   = 0;
		shadow_quot    = '0;
	end

	// '0'..'9' sit at 0x30 upwards, 'A'..'F' at 0x41 upwards
	function automatic logic [CHAR_BITS-1:0] ascii_of(input logic [DIGIT_BITS-1:0] d);
		if (d <= DIGIT_BITS'(9))
			return CHAR_BITS'(7'h30 | d);
		return CHAR_BITS'(7'h40 + (d - DIGIT_BITS'(9)));
	endfunction

	// Divide down, stack the remainders, then unstack them most significant first.
	task automatic predict_digits(input logic [IN_BITS-1:0] v, input logic [RADIX_BITS-1:0] r);
		logic [VALUE_BITS-1:0] rem;
		digit_beat_t           beat;
		if (v[IN_BITS-1] || v == '0 || r < RADIX_MIN || r > RADIX_MAX)
			return;
		shadow_depth = 0;
		shadow_quot  = v[VALUE_BITS-1:0];
		while (shadow_quot != '0) begin
			rem         = shadow_quot % VALUE_BITS'(r);
			shadow_quot = shadow_quot / VALUE_BITS'(r);
			if (shadow_depth < MAX_DIGITS) begin
				shadow_stack[shadow_depth] = rem[DIGIT_BITS-1:0];
				shadow_depth++;
			end
		end
		while (shadow_depth > 0) begin
			shadow_depth--;
			beat.dval  = shadow_stack[shadow_depth];
			beat.dchar = ascii_of(beat.dval);
			beat.dlast = (shadow_depth == 0);
			digit_fifo.push_back(beat);
		end
	endtask

	task automatic check_digit();
		digit_beat_t exp_beat;
		digit_beat_t got_beat;
		got_beat.dval  = m_tdata[DIGIT_BITS-1:0];
		got_beat.dchar = m_tdata[DIGIT_BITS +: CHAR_BITS];
		got_beat.dlast = m_tlast;
		if (digit_fifo.size() == 0) begin
			if (mismatch_total < REPORT_LIMIT)
				$display("%0t: unexpected digit beat: value %0d char %0d last %0b",
					$realtime, got_beat.dval, got_beat.dchar, got_beat.dlast);
			mismatch_total++;
			return;
		end
		exp_beat = digit_fifo.pop_front();
		if (got_beat.dval !== exp_beat.dval || got_beat.dchar !== exp_beat.dchar ||
				got_beat.dlast !== exp_beat.dlast) begin
			if (mismatch_total < REPORT_LIMIT)
				$display("%0t: digit mismatch: expected value %0d char %0d last %0b, got value %0d char %0d last %0b",
					$realtime, exp_beat.dval, exp_beat.dchar, exp_beat.dlast,
					got_beat.dval, got_beat.dchar, got_beat.dlast);
			mismatch_total++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_digits(s_tdata[IN_BITS-1:0], s_tdata[IN_BITS +: RADIX_BITS]);
			if (m_tvalid && m_tready)
				check_digit();
		end
		fail_count <= mismatch_total;
		pending    <= digit_fifo.size();
	end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives values and radices into the radix digit converter, directed corner
// cases first and then random beats, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
	import rdc_pkg::*;

	// well-formed random beats; noise beats come on top of these
	localparam int RANDOM_ITEMS = 380;
	// the last stretch of the run is driven without any idling
	localparam int CALM_TAIL    = 40;
	// one radix-2 conversion of the largest value plus margin
	localparam int DRAIN_CYCLES = 1100;

	logic                    clk      = 1'b0;
	logic                    arst_n   = 1'b0;
	logic                    s_tvalid = 1'b0;
	logic                    s_tready;
	logic [S_TDATA_BITS-1:0] s_tdata  = '0;
	logic                    m_tvalid;
	logic                    m_tready = 1'b0;
	logic [M_TDATA_BITS-1:0] m_tdata;
	logic                    m_tlast;
	logic                    calm     = 1'b0;
	int                      fail_count;
	int                      pending;

	radix_digit_converter_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	rdc_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 2 ns period
	initial begin
		forever #1 clk = ~clk;
	end

	// Present one beat, optionally after a random idle burst, and hold it until
	// taken. tvalid is only lowered when an idle burst really follows, so a
	// back-to-back beat never sees two assignments in one step.
	task automatic send_beat(input logic [IN_BITS-1:0] value, input logic [RADIX_BITS-1:0] radix);
		int gap;
		gap = 0;
		if (!calm && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 5);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			// scramble the bus while idle, the block must ignore it
			s_tdata  <= S_TDATA_BITS'({$urandom, $urandom});
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_BITS'({radix, value});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Positive values: full range, short ones, and values around powers of two.
	function automatic logic [IN_BITS-1:0] random_value();
		logic [IN_BITS-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom & 32'h7FFF_FFFF;
			1: v = $urandom_range(1, 255);
			2: v = $urandom_range(1, 65535);
			default: v = (32'd1 << $urandom_range(0, 30)) - $urandom_range(0, 1);
		endcase
		if (v == '0)
			v = 1;
		return v;
	endfunction

	// Beats that must produce nothing: negative, zero, or an unusable radix.
	task automatic send_noise();
		case ($urandom_range(0, 3))
			0: send_beat($urandom | 32'h8000_0000, $urandom_range(RADIX_MIN, RADIX_MAX));
			1: send_beat('0, $urandom_range(0, 31));
			2: send_beat(random_value(), $urandom_range(0, 1));
			default: send_beat(random_value(), $urandom_range(17, 31));
		endcase
	endtask

	// Sink side: random stall bursts, always ready in the calm tail.
	initial begin
		forever begin
			if (!calm && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: smallest and largest values, widest and narrowest radices
		send_beat(32'd1, 5'd2);
		send_beat(32'h7FFF_FFFF, 5'd2);             // longest run, 31 digits
		send_beat(32'h7FFF_FFFF, 5'd16);
		send_beat(32'h7FFF_FFFF, 5'd3);
		send_beat(32'd1234567890, 5'd10);
		send_beat(32'h0FED_CBA9, 5'd16);            // every letter digit
		send_beat(32'd15, 5'd16);                   // single letter digit
		send_beat(32'd16, 5'd16);
		send_beat(32'd9, 5'd10);
		send_beat(32'd10, 5'd11);
		send_beat(32'd255, 5'd15);
		send_beat(32'h4000_0000, 5'd2);
		send_beat(32'd7, 5'd8);
		// directed: beats that give no digits at all
		send_beat(32'd0, 5'd10);
		send_beat(32'hFFFF_FFFF, 5'd10);
		send_beat(32'h8000_0000, 5'd2);
		send_beat(32'd100, 5'd0);
		send_beat(32'd100, 5'd1);
		send_beat(32'd100, 5'd17);
		send_beat(32'd100, 5'd31);

		// random: mostly well-formed beats, noise sprinkled in
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - CALM_TAIL)
				calm <= 1'b1;
			if ($urandom_range(0, 5) == 0)
				send_noise();
			send_beat(random_value(), $urandom_range(RADIX_MIN, RADIX_MAX));
		end
		s_tvalid <= 1'b0;

		// drain: wait for every predicted digit, then watch for strays
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: several times the slowest legal run.
	initial begin
		#6_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
